// File: sv/crc32s_pkg.sv
// shared constants, types and elaboration-time helpers for the crc32 slice-by-8 stream
// used by the lane, merge and top-level modules; no dependencies
`timescale 1ns / 1ps

package crc32s_pkg;

  localparam int BYTES_PER_WORD = 8;
  localparam int COUNT_W        = 5;
  localparam int CRC_W          = 32;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               first;
    logic [CRC_W-1:0]   seed;
  } stage_ctrl_t;

  // advance a reflected crc register over nbytes zero bytes (elaboration only)
  function automatic logic [CRC_W-1:0] crc_advance(input logic [CRC_W-1:0] c,
                                                   input int nbytes);
    logic [CRC_W-1:0] r;
    r = c;
    for (int i = 0; i < 8 * nbytes; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// File: sv/crc32s_lane.sv
// one byte lane: contribution of its byte to the word crc, shifted by the bytes after it
// depends on crc32s_pkg
`timescale 1ns / 1ps

module crc32s_lane #(
  parameter int BYTES_PER_WORD = crc32s_pkg::BYTES_PER_WORD,
  parameter int LANE           = 0
) (
  input  logic [7:0]                      data_byte,
  input  logic [crc32s_pkg::COUNT_W-1:0]  count,
  output logic [crc32s_pkg::CRC_W-1:0]    contrib
);

  localparam int CW = crc32s_pkg::COUNT_W;
  localparam int KW = (BYTES_PER_WORD > 1) ? $clog2(BYTES_PER_WORD) : 1;

  logic [crc32s_pkg::CRC_W-1:0] cols [BYTES_PER_WORD][8];
  logic [CW-1:0]                trail;
  logic [crc32s_pkg::CRC_W-1:0] acc;

  // column j of table k: bit j of the byte followed by k zero bytes
  for (genvar k = 0; k < BYTES_PER_WORD; k++) begin : g_tab
    for (genvar j = 0; j < 8; j++) begin : g_col
      localparam logic [crc32s_pkg::CRC_W-1:0] COL =
        crc32s_pkg::crc_advance(crc32s_pkg::CRC_W'(1) << j, k + 1);
      assign cols[k][j] = COL;
    end
  end

  assign trail = count - CW'(LANE + 1);

  always_comb begin
    acc = '0;
    if (count > CW'(LANE)) begin
      for (int j = 0; j < 8; j++) begin
        if (data_byte[j]) acc = acc ^ cols[trail[KW-1:0]][j];
      end
    end
    contrib = acc;
  end

endmodule

// File: sv/crc32s_merge.sv
// merging stage: folds the lane results with the running crc advanced by the byte count
// depends on crc32s_pkg
`timescale 1ns / 1ps

module crc32s_merge #(
  parameter int BYTES_PER_WORD = crc32s_pkg::BYTES_PER_WORD
) (
  input  logic [BYTES_PER_WORD-1:0][crc32s_pkg::CRC_W-1:0] lane_crc,
  input  crc32s_pkg::stage_ctrl_t                          ctrl,
  input  logic [crc32s_pkg::CRC_W-1:0]                     running_crc,
  output logic [crc32s_pkg::CRC_W-1:0]                     crc_next
);

  localparam int CRC_W = crc32s_pkg::CRC_W;
  localparam int NW    = $clog2(BYTES_PER_WORD + 1);

  logic [CRC_W-1:0] zcols [BYTES_PER_WORD+1][CRC_W];
  logic [CRC_W-1:0] start_inv;
  logic [CRC_W-1:0] adv;
  logic [CRC_W-1:0] data_part;

  // zero-byte advance matrices, one per possible byte count
  for (genvar n = 0; n <= BYTES_PER_WORD; n++) begin : g_adv
    for (genvar j = 0; j < CRC_W; j++) begin : g_col
      localparam logic [CRC_W-1:0] COL = crc32s_pkg::crc_advance(CRC_W'(1) << j, n);
      assign zcols[n][j] = COL;
    end
  end

  assign start_inv = ~(ctrl.first ? ctrl.seed : running_crc);

  always_comb begin
    adv       = '0;
    data_part = '0;
    for (int j = 0; j < CRC_W; j++) begin
      if (start_inv[j]) adv = adv ^ zcols[ctrl.count[NW-1:0]][j];
    end
    for (int i = 0; i < BYTES_PER_WORD; i++) begin
      data_part = data_part ^ lane_crc[i];
    end
    crc_next = ~(adv ^ data_part);
  end

endmodule

// File: sv/crc32_slice8_stream.sv
// top level of the streaming crc-32 block: lane stage, merge stage and output register
// depends on crc32s_pkg, crc32s_lane and crc32s_merge
`timescale 1ns / 1ps

// Streaming CRC-32 (IEEE 802.3, reflected polynomial, with the usual initial and
// final inversion) over a byte stream. Each input transfer carries up to eight
// bytes in data_word, first byte in bits 7:0, and byte_count says how many are
// valid; counts above the word size saturate at the word size, a count of zero
// absorbs nothing. With first set the word continues from seed (0 for a fresh
// message), otherwise from the previous result, so crc_value is always the
// finished CRC of everything absorbed so far. One result transfer follows every
// input transfer. It takes one word every cycle unless in_stall is high. Each
// word runs through one lane per byte, each with its byte's table shifted by
// the bytes after it, into the lane stage register; the merge stage closes the
// loop through the running crc in the output register, advancing it by the
// byte count and merging the lanes; that feedback sets the single-cycle rate.

module crc32_slice8_stream #(
  parameter int BYTES_PER_WORD = crc32s_pkg::BYTES_PER_WORD
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        first,
  input  logic [31:0] seed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] crc_value
);

  localparam int CW    = crc32s_pkg::COUNT_W;
  localparam int CRC_W = crc32s_pkg::CRC_W;

  // lane stage signals
  logic [CW-1:0]                           sat_count;
  logic [BYTES_PER_WORD-1:0][CRC_W-1:0]    lane_out;
  crc32s_pkg::stage_ctrl_t                 in_ctrl;

  // lane stage register
  logic                                    a_valid;
  logic [BYTES_PER_WORD-1:0][CRC_W-1:0]    a_lane;
  crc32s_pkg::stage_ctrl_t                 a_ctrl;

  // merge stage
  logic [CRC_W-1:0]                        crc_next;
  logic                                    out_free;
  logic                                    in_take;
  logic                                    a_move;

  // byte count saturates at the word size
  assign sat_count = ({1'b0, byte_count} > CW'(BYTES_PER_WORD)) ?
                     CW'(BYTES_PER_WORD) : {1'b0, byte_count};

  assign in_ctrl.count = sat_count;
  assign in_ctrl.first = first;
  assign in_ctrl.seed  = seed;

  // one lane per byte position; positions past the data word read as zero
  for (genvar i = 0; i < BYTES_PER_WORD; i++) begin : g_lane
    logic [7:0] lane_byte;
    if (i < 8) begin : g_data
      assign lane_byte = data_word[8*i +: 8];
    end else begin : g_pad
      assign lane_byte = 8'h00;
    end
    crc32s_lane #(
      .BYTES_PER_WORD (BYTES_PER_WORD),
      .LANE           (i)
    ) u_lane (
      .data_byte (lane_byte),
      .count     (sat_count),
      .contrib   (lane_out[i])
    );
  end

  // the output register doubles as the running crc
  crc32s_merge #(
    .BYTES_PER_WORD (BYTES_PER_WORD)
  ) u_merge (
    .lane_crc    (a_lane),
    .ctrl        (a_ctrl),
    .running_crc (crc_value),
    .crc_next    (crc_next)
  );

  // handshake: the lane stage only waits while the output register is full and stalled
  assign out_free = !out_valid || !out_stall;
  assign in_stall = a_valid && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign a_move   = a_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_take) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  // lane payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      a_lane <= lane_out;
      a_ctrl <= in_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      crc_value <= '0;
    end else if (a_move) begin
      out_valid <= 1'b1;
      crc_value <= crc_next;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // stalling upstream only happens with both stages full and the output held
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (a_valid && out_valid && out_stall))
    else $error("input stalled without a full pipeline");

  // a word leaving the lane stage always lands in the output register
  assert property (@(posedge clk) disable iff (rst)
    a_move |=> (out_valid && crc_value == $past(crc_next)))
    else $error("merged crc lost");

  // a blocked lane stage keeps its contents
  assert property (@(posedge clk) disable iff (rst)
    (a_valid && !out_free) |=> (a_valid && $stable(a_lane) && $stable(a_ctrl)))
    else $error("lane stage changed while blocked");

  // the running crc only moves when a result is produced
  assert property (@(posedge clk) disable iff (rst)
    !a_move |=> $stable(crc_value))
    else $error("running crc changed without a result");

  // reset empties the pipeline and clears the running crc
  assert property (@(posedge clk)
    rst |=> (!out_valid && !a_valid && crc_value == '0))
    else $error("reset state wrong");
`endif

endmodule
